### design/dbc_pkg.sv
// ----------------------------------------------------------------------------
// dbc_pkg: descriptor block checker shared definitions
// Header layout constants, status codes, result record and the byte-wide
// reflected CRC-32 update.
// ----------------------------------------------------------------------------
package dbc_pkg;

   localparam int unsigned POS_W       = 7;
   localparam int unsigned LEN_W       = 16;
   localparam int unsigned CRC_W       = 32;
   localparam logic [CRC_W-1:0] CRC_POLY = 32'hedb88320;
   localparam logic [CRC_W-1:0] CRC_ONES = 32'hffffffff;

   // Header offsets
   localparam logic [POS_W-1:0] POS_VERSION   = 7'd4;
   localparam logic [POS_W-1:0] POS_FLAGS     = 7'd5;
   localparam logic [POS_W-1:0] POS_LEN_LO    = 7'd6;
   localparam logic [POS_W-1:0] POS_LEN_HI    = 7'd7;
   localparam logic [POS_W-1:0] POS_GEN       = 7'd8;
   localparam logic [POS_W-1:0] POS_PCRC      = 7'd12;
   localparam logic [POS_W-1:0] POS_HCRC      = 7'd16;
   localparam logic [POS_W-1:0] POS_PAYLOAD   = 7'd20;

   localparam logic [7:0] VERSION_ONE = 8'h01;
   localparam logic [7:0] FLAG_RSVD   = 8'hfe;
   localparam logic [7:0] FLAG_EMPTY  = 8'h01;

   // Magic "KDSC", first byte in bits 7:0
   localparam logic [31:0] MAGIC = 32'h4353444b;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_PROTOCOL = 2'd1,
      STATUS_CRC      = 2'd2
   } status_type;

   typedef struct packed {
      logic             kind;
      logic [7:0]       payload_byte;
      logic [6:0]       payload_index;
      status_type       status;
      logic [7:0]       header_version;
      logic             flags;
      logic [6:0]       body_length;
      logic [31:0]      generation;
      logic [31:0]      payload_crc;
   } rsp_type;

   // One byte through the reflected CRC-32, LSB first
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [7:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
      end
      return c;
   endfunction

endpackage

### design/descriptor_block_checker_core.sv
// ----------------------------------------------------------------------------
// descriptor_block_checker_core: descriptor block deframer and checker
// Checks the header of a fixed-size descriptor block, runs header and payload
// CRC-32, passes payload bytes through and reports a summary on the last byte.
// ----------------------------------------------------------------------------
// A transfer's result is registered in the output register or the skid entry.
// Throughput: one byte per cycle while the skid entry is empty; the byte-wide CRC
// update and header checks sit between the block state and the output register.
// A two-deep output buffer keeps bytes flowing while one result waits.
// Reset: synchronous, clears position, CRCs, header state and result valids.
module descriptor_block_checker_core #(
   parameter int unsigned BLOCK_BYTES   = 128,
   parameter int unsigned PAYLOAD_LIMIT = 108
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_kind,
   output logic [7:0] rsp_payload_byte,
   output logic [6:0] rsp_payload_index,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_header_version,
   output logic       rsp_flags,
   output logic [6:0] rsp_body_length,
   output logic [31:0] rsp_generation,
   output logic [31:0] rsp_payload_crc
);
   import dbc_pkg::*;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_BYTES - 1);
   localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(PAYLOAD_LIMIT);

   // Block state
   logic [POS_W-1:0] byte_position_ff, byte_position_in;
   logic [CRC_W-1:0] header_crc_ff, header_crc_in;
   logic [CRC_W-1:0] payload_crc_ff, payload_crc_in;
   logic             header_bad_ff, header_bad_in;
   logic [7:0]       flag_byte_ff, flag_byte_in;
   logic [LEN_W-1:0] length_word_ff, length_word_in;
   logic [31:0]      generation_ff, generation_in;
   logic [31:0]      stored_pcrc_ff, stored_pcrc_in;
   logic [31:0]      stored_hcrc_ff, stored_hcrc_in;

   // Output buffer
   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_ff, skid_ff;

   logic       req_xfer, out_xfer, last, passed, produce;
   logic [6:0] idx;
   rsp_type    result;

   assign req_stall = skid_valid_ff;
   assign req_xfer  = req_valid && !req_stall;
   assign out_xfer  = out_valid_ff && !rsp_stall;

   // Header parse, CRC update and summary
   always_comb begin
      logic [POS_W-1:0] pos;
      logic [LEN_W-1:0] len_new;
      logic [1:0]       lane;
      pos  = byte_position_ff;
      lane = pos[1:0];
      byte_position_in = pos + 7'd1;
      header_crc_in  = header_crc_ff;
      payload_crc_in = payload_crc_ff;
      header_bad_in  = header_bad_ff;
      flag_byte_in   = flag_byte_ff;
      length_word_in = length_word_ff;
      generation_in  = generation_ff;
      stored_pcrc_in = stored_pcrc_ff;
      stored_hcrc_in = stored_hcrc_ff;
      passed  = 1'b0;
      idx     = '0;
      last    = pos >= LAST_POS;
      len_new = {req_data_byte, length_word_ff[7:0]};

      if (pos < POS_HCRC) begin
         header_crc_in = crc_byte(header_crc_ff, req_data_byte);
      end
      if (pos < POS_VERSION) begin
         if (req_data_byte != MAGIC[8*lane +: 8]) header_bad_in = 1'b1;
      end else if (pos == POS_VERSION) begin
         if (req_data_byte != VERSION_ONE) header_bad_in = 1'b1;
      end else if (pos == POS_FLAGS) begin
         flag_byte_in = req_data_byte;
      end else if (pos == POS_LEN_LO) begin
         length_word_in = {8'd0, req_data_byte};
      end else if (pos == POS_LEN_HI) begin
         length_word_in = len_new;
         if ((flag_byte_ff & FLAG_RSVD) != 8'd0 || len_new > LEN_MAX ||
             ((flag_byte_ff & FLAG_EMPTY) != 8'd0 && len_new != '0)) begin
            header_bad_in = 1'b1;
         end
      end else if (pos < POS_PCRC) begin
         generation_in[8*lane +: 8] = req_data_byte;
      end else if (pos < POS_HCRC) begin
         stored_pcrc_in[8*lane +: 8] = req_data_byte;
      end else if (pos < POS_PAYLOAD) begin
         stored_hcrc_in[8*lane +: 8] = req_data_byte;
      end else begin
         idx = pos - POS_PAYLOAD;
         if ({9'd0, idx} < length_word_ff) begin
            payload_crc_in = crc_byte(payload_crc_ff, req_data_byte);
            passed = 1'b1;
         end
      end

      // Result record
      result = '0;
      result.kind = last;
      if (passed) begin
         result.payload_byte  = req_data_byte;
         result.payload_index = idx;
      end
      if (last) begin
         if (header_bad_in) begin
            result.status = STATUS_PROTOCOL;
         end else if ((header_crc_in ^ CRC_ONES) != stored_hcrc_in ||
                      (payload_crc_in ^ CRC_ONES) != stored_pcrc_in) begin
            result.status = STATUS_CRC;
         end else begin
            result.status         = STATUS_OK;
            result.header_version = VERSION_ONE;
            result.flags          = flag_byte_in[0];
            result.body_length    = length_word_in[6:0];
            result.generation     = generation_in;
            result.payload_crc    = stored_pcrc_in;
         end
         // Block done: back to the reset state
         byte_position_in = '0;
         header_crc_in    = CRC_ONES;
         payload_crc_in   = CRC_ONES;
         header_bad_in    = 1'b0;
         flag_byte_in     = '0;
         length_word_in   = '0;
         generation_in    = '0;
         stored_pcrc_in   = '0;
         stored_hcrc_in   = '0;
      end
      produce = req_xfer && (passed || last);
   end

   // Block state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         header_crc_ff    <= CRC_ONES;
         payload_crc_ff   <= CRC_ONES;
         header_bad_ff    <= 1'b0;
         flag_byte_ff     <= '0;
         length_word_ff   <= '0;
         generation_ff    <= '0;
         stored_pcrc_ff   <= '0;
         stored_hcrc_ff   <= '0;
      end else if (req_xfer) begin
         byte_position_ff <= byte_position_in;
         header_crc_ff    <= header_crc_in;
         payload_crc_ff   <= payload_crc_in;
         header_bad_ff    <= header_bad_in;
         flag_byte_ff     <= flag_byte_in;
         length_word_ff   <= length_word_in;
         generation_ff    <= generation_in;
         stored_pcrc_ff   <= stored_pcrc_in;
         stored_hcrc_ff   <= stored_hcrc_in;
      end
   end

   // Output register plus skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_xfer) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (produce) begin
         if (!out_valid_ff || out_xfer) begin
            out_ff       <= result;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (out_xfer) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_ff.kind;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_payload_index  = out_ff.payload_index;
   assign rsp_status         = out_ff.status;
   assign rsp_header_version = out_ff.header_version;
   assign rsp_flags          = out_ff.flags;
   assign rsp_body_length    = out_ff.body_length;
   assign rsp_generation     = out_ff.generation;
   assign rsp_payload_crc    = out_ff.payload_crc;

   // Checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_block_restart: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && last) |=> (byte_position_ff == '0 && header_crc_ff == CRC_ONES))
      else $error("block state not cleared after summary");

   a_pass_no_status: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.kind) |-> (out_ff.status == STATUS_OK &&
                                         out_ff.generation == '0))
      else $error("pass-through byte carries summary fields");

   a_bad_zero_header: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status != STATUS_OK) |->
         (out_ff.header_version == '0 && out_ff.payload_crc == '0))
      else $error("failed summary carries header values");

endmodule

### tb/sv/tb_descriptor_block_checker_core.sv
// ----------------------------------------------------------------------------
// tb_descriptor_block_checker_core: self-checking bench for the block checker
// Feeds 128-byte descriptor blocks, some well formed with random content and
// the rest with header, CRC or length defects or pure noise. A built-in
// predictor tracks each accepted byte and queues the expected pass-through and
// summary transfers; the monitor checks every result transfer field by field.
// Random idle bursts on both channels, none in the final blocks.
// ----------------------------------------------------------------------------
module tb_descriptor_block_checker_core;
   import dbc_pkg::*;

   localparam int unsigned BLOCK_BYTES   = 128;
   localparam int unsigned PAYLOAD_LIMIT = 108;
   localparam int unsigned CALM_TAIL     = 3 * BLOCK_BYTES;
   localparam int unsigned RANDOM_BLOCKS = 2;
   localparam int unsigned TAIL_CYCLES   = 20;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam logic [31:0] MAGIC_WORD    = 32'h4353444b;  // "KDSC", byte 0 in bits 7:0

   // Ways a generated block departs from a clean one
   typedef enum int {
      DEFECT_NONE,
      DEFECT_MAGIC,
      DEFECT_VERSION,
      DEFECT_RSVD_FLAG,
      DEFECT_HDR_CRC,
      DEFECT_PAY_CRC,
      DEFECT_NOISE
   } defect_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_payload_byte;
   logic [6:0]  rsp_payload_index;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_header_version;
   logic        rsp_flags;
   logic [6:0]  rsp_body_length;
   logic [31:0] rsp_generation;
   logic [31:0] rsp_payload_crc;

   descriptor_block_checker_core #(
      .BLOCK_BYTES   (BLOCK_BYTES),
      .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_status         (rsp_status),
      .rsp_header_version (rsp_header_version),
      .rsp_flags          (rsp_flags),
      .rsp_body_length    (rsp_body_length),
      .rsp_generation     (rsp_generation),
      .rsp_payload_crc    (rsp_payload_crc)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logic [7:0]  block_bytes_q [$];
   rsp_type     predicted_rsp [$];
   int unsigned bytes_total = 0;
   int unsigned bytes_done = 0;
   int unsigned error_count = 0;
   int unsigned rsp_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap = 0;
   int unsigned hold_left = 0;

   // Predictor state for the block in flight
   logic [6:0]  blk_pos;
   logic [31:0] hdr_crc_acc;
   logic [31:0] pay_crc_acc;
   logic        hdr_bad;
   logic [7:0]  flag_reg;
   logic [15:0] len_reg;
   logic [31:0] gen_reg;
   logic [31:0] pay_crc_stored;
   logic [31:0] hdr_crc_stored;

   // Reflected CRC-32, one byte, LSB first
   function automatic logic [31:0] crc32_update(input logic [31:0] acc, input logic [7:0] b);
      logic [31:0] c;
      c = acc;
      for (int k = 0; k < 8; k++) begin
         if (c[0] ^ b[k]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   task automatic clear_block_state();
      blk_pos        = '0;
      hdr_crc_acc    = CRC_ONES;
      pay_crc_acc    = CRC_ONES;
      hdr_bad        = 1'b0;
      flag_reg       = '0;
      len_reg        = '0;
      gen_reg        = '0;
      pay_crc_stored = '0;
      hdr_crc_stored = '0;
   endtask

   // Advance the predictor by one accepted byte and queue what it yields
   task automatic track_block_byte(input logic [7:0] b);
      rsp_type    r;
      logic       passed;
      logic [6:0] idx;
      r = '0;
      passed = 1'b0;
      idx = '0;
      if (blk_pos < POS_HCRC) begin
         hdr_crc_acc = crc32_update(hdr_crc_acc, b);
      end
      if (blk_pos < POS_VERSION) begin
         if (b != MAGIC_WORD[{blk_pos[1:0], 3'b000} +: 8]) hdr_bad = 1'b1;
      end else if (blk_pos == POS_VERSION) begin
         if (b != VERSION_ONE) hdr_bad = 1'b1;
      end else if (blk_pos == POS_FLAGS) begin
         flag_reg = b;
      end else if (blk_pos == POS_LEN_LO) begin
         len_reg = {8'd0, b};
      end else if (blk_pos == POS_LEN_HI) begin
         len_reg = {b, len_reg[7:0]};
         if ((flag_reg & FLAG_RSVD) != 0 || len_reg > PAYLOAD_LIMIT ||
             (flag_reg[0] && len_reg != 0)) begin
            hdr_bad = 1'b1;
         end
      end else if (blk_pos < POS_PCRC) begin
         gen_reg[{blk_pos[1:0], 3'b000} +: 8] = b;
      end else if (blk_pos < POS_HCRC) begin
         pay_crc_stored[{blk_pos[1:0], 3'b000} +: 8] = b;
      end else if (blk_pos < POS_PAYLOAD) begin
         hdr_crc_stored[{blk_pos[1:0], 3'b000} +: 8] = b;
      end else begin
         idx = blk_pos - POS_PAYLOAD;
         if (idx < len_reg) begin
            pay_crc_acc = crc32_update(pay_crc_acc, b);
            passed = 1'b1;
         end
      end

      if (passed) begin
         r.payload_byte  = b;
         r.payload_index = idx;
      end

      if (blk_pos != BLOCK_BYTES - 1) begin
         blk_pos = blk_pos + 7'd1;
         if (passed) predicted_rsp.push_back(r);
      end else begin
         // Last byte: summary, then start over
         r.kind = 1'b1;
         if (hdr_bad) begin
            r.status = STATUS_PROTOCOL;
         end else if ((hdr_crc_acc ^ CRC_ONES) != hdr_crc_stored ||
                      (pay_crc_acc ^ CRC_ONES) != pay_crc_stored) begin
            r.status = STATUS_CRC;
         end else begin
            r.status         = STATUS_OK;
            r.header_version = VERSION_ONE;
            r.flags          = flag_reg[0];
            r.body_length    = len_reg[6:0];
            r.generation     = gen_reg;
            r.payload_crc    = pay_crc_stored;
         end
         predicted_rsp.push_back(r);
         clear_block_state();
      end
      bytes_done++;
   endtask

   // Build one block with the given header fields and defect, queue its bytes
   task automatic queue_block(input defect_type defect, input logic [15:0] length,
                              input logic [7:0] flag_val);
      logic [7:0]  blk [BLOCK_BYTES];
      logic [31:0] pcrc;
      logic [31:0] hcrc;
      int          k;
      for (int i = 0; i < BLOCK_BYTES; i++) blk[i] = 8'($urandom_range(0, 255));
      if (defect != DEFECT_NOISE) begin
         for (int i = 0; i < 4; i++) blk[i] = MAGIC_WORD[8*i +: 8];
         blk[POS_VERSION] = VERSION_ONE;
         blk[POS_FLAGS]   = flag_val;
         blk[POS_LEN_LO]  = length[7:0];
         blk[POS_LEN_HI]  = length[15:8];
         case (defect)
            DEFECT_MAGIC: begin
               k = int'($urandom_range(0, 3));
               blk[k] = blk[k] ^ 8'($urandom_range(1, 255));
            end
            DEFECT_VERSION:   blk[POS_VERSION] = blk[POS_VERSION] ^ 8'($urandom_range(1, 255));
            DEFECT_RSVD_FLAG: blk[POS_FLAGS] = flag_val | 8'($urandom_range(1, 127) << 1);
            default: ;
         endcase
         // Payload CRC over the bytes actually present
         pcrc = CRC_ONES;
         for (int i = 0; i < length && POS_PAYLOAD + i < BLOCK_BYTES; i++) begin
            pcrc = crc32_update(pcrc, blk[POS_PAYLOAD + i]);
         end
         pcrc = pcrc ^ CRC_ONES;
         if (defect == DEFECT_PAY_CRC) pcrc = pcrc ^ (32'd1 << $urandom_range(0, 31));
         for (int i = 0; i < 4; i++) blk[POS_PCRC + i] = pcrc[8*i +: 8];
         hcrc = CRC_ONES;
         for (int i = 0; i < POS_HCRC; i++) hcrc = crc32_update(hcrc, blk[i]);
         hcrc = hcrc ^ CRC_ONES;
         if (defect == DEFECT_HDR_CRC) hcrc = hcrc ^ (32'd1 << $urandom_range(0, 31));
         for (int i = 0; i < 4; i++) blk[POS_HCRC + i] = hcrc[8*i +: 8];
      end
      for (int i = 0; i < BLOCK_BYTES; i++) block_bytes_q.push_back(blk[i]);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at result %0d: %s got %0h expected %0h", rsp_count, what, got, want);
      error_count++;
   endtask

   // Compare one result transfer with the oldest prediction
   task automatic check_result();
      rsp_type got;
      rsp_type want;
      got.kind           = rsp_kind;
      got.payload_byte   = rsp_payload_byte;
      got.payload_index  = rsp_payload_index;
      got.status         = status_type'(rsp_status);
      got.header_version = rsp_header_version;
      got.flags          = rsp_flags;
      got.body_length    = rsp_body_length;
      got.generation     = rsp_generation;
      got.payload_crc    = rsp_payload_crc;
      if (predicted_rsp.size() == 0) begin
         report_mismatch("unexpected transfer, kind", 32'(got.kind), 32'd0);
      end else begin
         want = predicted_rsp.pop_front();
         if (got.kind !== want.kind)
            report_mismatch("kind", 32'(got.kind), 32'(want.kind));
         if (got.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
         if (got.payload_index !== want.payload_index)
            report_mismatch("payload_index", 32'(got.payload_index),
                            32'(want.payload_index));
         if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
         if (got.header_version !== want.header_version)
            report_mismatch("header_version", 32'(got.header_version),
                            32'(want.header_version));
         if (got.flags !== want.flags)
            report_mismatch("flags", 32'(got.flags), 32'(want.flags));
         if (got.body_length !== want.body_length)
            report_mismatch("body_length", 32'(got.body_length), 32'(want.body_length));
         if (got.generation !== want.generation)
            report_mismatch("generation", got.generation, want.generation);
         if (got.payload_crc !== want.payload_crc)
            report_mismatch("payload_crc", got.payload_crc, want.payload_crc);
      end
      rsp_count++;
   endtask

   // Byte driver: predict on each transfer, then load the next byte or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data_byte <= 8'd0;
      end else begin
         if (req_valid && !req_stall) track_block_byte(req_data_byte);
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (block_bytes_q.size() > CALM_TAIL && $urandom_range(0, 15) == 0) begin
               send_gap <= $urandom_range(0, 14);
               req_valid <= 1'b0;
            end else if (block_bytes_q.size() != 0) begin
               req_valid <= 1'b1;
               req_data_byte <= block_bytes_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (block_bytes_q.size() > CALM_TAIL && $urandom_range(0, 11) == 0) begin
            hold_left <= $urandom_range(0, 14);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      logic [15:0] length;
      logic [7:0]  flag_val;
      clear_block_state();

      // Directed blocks: clean extremes first, then defects
      queue_block(DEFECT_NONE, 16'd0, FLAG_EMPTY);
      queue_block(DEFECT_NONE, 16'(PAYLOAD_LIMIT), 8'd0);  // last byte is also payload
      queue_block(DEFECT_NONE, 16'd3, FLAG_EMPTY);          // empty but nonzero length
      queue_block(DEFECT_HDR_CRC, 16'h0100, 8'd0);          // protocol error beats CRC
      queue_block(DEFECT_MAGIC, 16'd20, 8'd0);
      queue_block(DEFECT_PAY_CRC, 16'd50, 8'd0);

      // Random blocks, mostly well formed
      for (int n = 0; n < RANDOM_BLOCKS; n++) begin
         case ($urandom_range(0, 3))
            0:       length = 16'($urandom_range(0, 8));
            1:       length = 16'($urandom_range(PAYLOAD_LIMIT - 8, PAYLOAD_LIMIT));
            default: length = 16'($urandom_range(0, PAYLOAD_LIMIT));
         endcase
         flag_val = 8'd0;
         if ($urandom_range(0, 3) == 0) begin
            flag_val = FLAG_EMPTY;
            length = 16'd0;
         end
         case ($urandom_range(0, 9))
            6:  queue_block(defect_type'($urandom_range(DEFECT_MAGIC, DEFECT_RSVD_FLAG)),
                            length, flag_val);
            7:  queue_block(defect_type'($urandom_range(DEFECT_HDR_CRC, DEFECT_PAY_CRC)),
                            length, flag_val);
            8: begin
               if ($urandom_range(0, 1) == 0) begin
                  queue_block(DEFECT_NONE, 16'($urandom_range(PAYLOAD_LIMIT + 1, 16'hffff)),
                              8'd0);
               end else begin
                  queue_block(DEFECT_NONE, 16'($urandom_range(1, PAYLOAD_LIMIT)), FLAG_EMPTY);
               end
            end
            9:       queue_block(DEFECT_NOISE, length, flag_val);
            default: queue_block(DEFECT_NONE, length, flag_val);
         endcase
      end
      bytes_total = block_bytes_q.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Drain: all bytes taken and every prediction matched
      while (bytes_done != bytes_total || predicted_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### descriptor_block_checker_core.f
design/dbc_pkg.sv
design/descriptor_block_checker_core.sv
tb/sv/tb_descriptor_block_checker_core.sv
